// ===== rtl/elf_relocation_patcher_defines.svh =====
// ----------------------------------------------------------------------------
// elf_relocation_patcher_defines
// Assertion macros shared by the relocation patcher RTL.
// ----------------------------------------------------------------------------
`ifndef ELF_RELOCATION_PATCHER_DEFINES_SVH
`define ELF_RELOCATION_PATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clock, off during reset
`define ERP_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("relocation patcher check failed");

// next-cycle implication, sampled on clock, off during reset
`define ERP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("relocation patcher check failed");

`else

`define ERP_ASSERT_IMPLY(lbl, ante, cons)
`define ERP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/erp_pkg.sv =====
// ----------------------------------------------------------------------------
// erp_pkg
// Codes, relocation type numbers and stage bundles of the relocation patcher.
// ----------------------------------------------------------------------------
package erp_pkg;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNSUP = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // write size codes
   localparam logic [1:0] SZ_NONE = 2'd0;
   localparam logic [1:0] SZ_W32  = 2'd1;
   localparam logic [1:0] SZ_W64  = 2'd2;

   // target isa select
   localparam logic ISA_X86   = 1'b0;
   localparam logic ISA_A64   = 1'b1;
   localparam logic ISA_RESET = ISA_A64;

   // relocation types shared by both isas
   localparam logic [8:0] R_NONE = 9'd0;

   // x86-64 relocation types
   localparam logic [8:0] X86_64    = 9'd1;
   localparam logic [8:0] X86_PC32  = 9'd2;
   localparam logic [8:0] X86_PLT32 = 9'd4;
   localparam logic [8:0] X86_32    = 9'd10;
   localparam logic [8:0] X86_32S   = 9'd11;
   localparam logic [8:0] X86_PC64  = 9'd24;

   // aarch64 relocation types
   localparam logic [8:0] A64_ABS64        = 9'd257;
   localparam logic [8:0] A64_ABS32        = 9'd258;
   localparam logic [8:0] A64_PREL64       = 9'd260;
   localparam logic [8:0] A64_PREL32       = 9'd261;
   localparam logic [8:0] A64_MOVW_G0      = 9'd263;
   localparam logic [8:0] A64_MOVW_G0_NC   = 9'd264;
   localparam logic [8:0] A64_MOVW_G1      = 9'd265;
   localparam logic [8:0] A64_MOVW_G1_NC   = 9'd266;
   localparam logic [8:0] A64_MOVW_G2      = 9'd267;
   localparam logic [8:0] A64_MOVW_G2_NC   = 9'd268;
   localparam logic [8:0] A64_MOVW_G3      = 9'd269;
   localparam logic [8:0] A64_LD_LO19      = 9'd273;
   localparam logic [8:0] A64_ADR_LO21     = 9'd274;
   localparam logic [8:0] A64_ADRP         = 9'd275;
   localparam logic [8:0] A64_ADRP_NC      = 9'd276;
   localparam logic [8:0] A64_ADD_LO12     = 9'd277;
   localparam logic [8:0] A64_LDST8_LO12   = 9'd278;
   localparam logic [8:0] A64_TSTBR14      = 9'd279;
   localparam logic [8:0] A64_CONDBR19     = 9'd280;
   localparam logic [8:0] A64_JUMP26       = 9'd282;
   localparam logic [8:0] A64_CALL26       = 9'd283;
   localparam logic [8:0] A64_LDST16_LO12  = 9'd284;
   localparam logic [8:0] A64_LDST32_LO12  = 9'd285;
   localparam logic [8:0] A64_LDST64_LO12  = 9'd286;
   localparam logic [8:0] A64_LDST128_LO12 = 9'd299;

   // item after the add stage
   typedef struct packed {
      logic        valid;
      logic        isa;
      logic [8:0]  rtype;
      logic [63:0] place;
      logic [63:0] value;
      logic [31:0] word;
   } erp_item_type;

   // finished result
   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [1:0]  size;
      logic [63:0] data;
   } erp_result_type;

endpackage

// ===== rtl/erp_add_stage.sv =====
// ----------------------------------------------------------------------------
// erp_add_stage
// Input register and the symbol plus addend adder stage.
// ----------------------------------------------------------------------------
module erp_add_stage
   import erp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         isa,
   input  logic [63:0]  patch_address,
   input  logic [63:0]  symbol_value,
   input  logic [63:0]  addend,
   input  logic [8:0]   reloc_type,
   input  logic [31:0]  old_word,
   output erp_item_type item
);

   typedef struct packed {
      logic        isa;
      logic [8:0]  rtype;
      logic [63:0] place;
      logic [63:0] sym;
      logic [63:0] addend;
      logic [31:0] word;
   } req_type;

   logic         req_valid_ff;
   logic         req_valid_in;
   req_type      req_ff;
   req_type      req_in;
   erp_item_type item_ff;
   erp_item_type item_in;

   // capture the accepted item
   always_comb begin
      req_valid_in  = accept;
      req_in.isa    = isa;
      req_in.rtype  = reloc_type;
      req_in.place  = patch_address;
      req_in.sym    = symbol_value;
      req_in.addend = addend;
      req_in.word   = old_word;
   end

   // value = symbol + addend, wrapping
   always_comb begin
      item_in.valid = req_valid_ff;
      item_in.isa   = req_ff.isa;
      item_in.rtype = req_ff.rtype;
      item_in.place = req_ff.place;
      item_in.value = req_ff.sym + req_ff.addend;
      item_in.word  = req_ff.word;
   end

   // valid bits cleared by reset, payload free running
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         item_ff.valid <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         item_ff.valid <= item_in.valid;
      end
      req_ff        <= req_in;
      item_ff.isa   <= item_in.isa;
      item_ff.rtype <= item_in.rtype;
      item_ff.place <= item_in.place;
      item_ff.value <= item_in.value;
      item_ff.word  <= item_in.word;
   end

   assign item = item_ff;

endmodule

// ===== rtl/erp_patch_stage.sv =====
// ----------------------------------------------------------------------------
// erp_patch_stage
// Relative distance, type decode, range checks, field insertion and the
// result register.
// ----------------------------------------------------------------------------
`include "elf_relocation_patcher_defines.svh"

module erp_patch_stage
   import erp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  erp_item_type   item,
   output erp_result_type result
);

   // true when v fits in n signed bits
   function automatic logic fits_s(input logic [63:0] v, input int unsigned n);
      logic [63:0] hi;
      hi = 64'($signed(v) >>> (n - 1));
      return (hi == '0) || (hi == '1);
   endfunction

   logic [63:0]    rel;
   logic [51:0]    pdiff;
   logic           pdiff_fits;
   logic [31:0]    w;
   logic [63:0]    d64;
   logic [1:0]     sz;
   logic           bad;
   logic           unsup;
   logic           use_word;
   erp_result_type res_ff;
   erp_result_type res_in;

   // pc-relative distance and page distance, in parallel
   assign rel        = item.value - item.place;
   assign pdiff      = item.value[63:12] - item.place[63:12];
   assign pdiff_fits = (&pdiff[51:20]) | ~(|pdiff[51:20]);

   // decode and field insertion
   always_comb begin
      w        = item.word;
      d64      = '0;
      sz       = SZ_W32;
      bad      = 1'b0;
      unsup    = 1'b0;
      use_word = 1'b0;
      if (item.isa == ISA_X86) begin
         unique case (item.rtype) inside
            R_NONE: sz = SZ_NONE;
            X86_64: begin
               sz  = SZ_W64;
               d64 = item.value;
            end
            X86_PC64: begin
               sz  = SZ_W64;
               d64 = rel;
            end
            X86_PC32, X86_PLT32: begin
               bad = !fits_s(rel, 32);
               d64 = {32'b0, rel[31:0]};
            end
            X86_32: begin
               bad = |item.value[63:32];
               d64 = {32'b0, item.value[31:0]};
            end
            X86_32S: begin
               bad = !fits_s(item.value, 32);
               d64 = {32'b0, item.value[31:0]};
            end
            default: unsup = 1'b1;
         endcase
      end else begin
         unique case (item.rtype) inside
            R_NONE: sz = SZ_NONE;
            A64_ABS64: begin
               sz  = SZ_W64;
               d64 = item.value;
            end
            A64_PREL64: begin
               sz  = SZ_W64;
               d64 = rel;
            end
            A64_ABS32: begin
               bad = |item.value[63:32];
               d64 = {32'b0, item.value[31:0]};
            end
            A64_PREL32: begin
               bad = !fits_s(rel, 32);
               d64 = {32'b0, rel[31:0]};
            end
            // movw immediate groups
            A64_MOVW_G0: begin
               bad      = |item.value[63:16];
               w[20:5]  = item.value[15:0];
               use_word = 1'b1;
            end
            A64_MOVW_G0_NC: begin
               w[20:5]  = item.value[15:0];
               use_word = 1'b1;
            end
            A64_MOVW_G1: begin
               bad      = |item.value[63:32];
               w[20:5]  = item.value[31:16];
               use_word = 1'b1;
            end
            A64_MOVW_G1_NC: begin
               w[20:5]  = item.value[31:16];
               use_word = 1'b1;
            end
            A64_MOVW_G2: begin
               bad      = |item.value[63:48];
               w[20:5]  = item.value[47:32];
               use_word = 1'b1;
            end
            A64_MOVW_G2_NC: begin
               w[20:5]  = item.value[47:32];
               use_word = 1'b1;
            end
            A64_MOVW_G3: begin
               w[20:5]  = item.value[63:48];
               use_word = 1'b1;
            end
            // literal loads and conditional branches
            A64_LD_LO19, A64_CONDBR19: begin
               bad      = !fits_s(rel, 21) || (|rel[1:0]);
               w[23:5]  = rel[20:2];
               use_word = 1'b1;
            end
            A64_TSTBR14: begin
               bad      = !fits_s(rel, 16) || (|rel[1:0]);
               w[18:5]  = rel[15:2];
               use_word = 1'b1;
            end
            A64_JUMP26, A64_CALL26: begin
               bad      = !fits_s(rel, 28) || (|rel[1:0]);
               w[25:0]  = rel[27:2];
               use_word = 1'b1;
            end
            // adr and adrp
            A64_ADR_LO21: begin
               bad      = !fits_s(rel, 21);
               w[30:29] = rel[1:0];
               w[23:5]  = rel[20:2];
               use_word = 1'b1;
            end
            A64_ADRP: begin
               bad      = !pdiff_fits;
               w[30:29] = pdiff[1:0];
               w[23:5]  = pdiff[20:2];
               use_word = 1'b1;
            end
            A64_ADRP_NC: begin
               w[30:29] = pdiff[1:0];
               w[23:5]  = pdiff[20:2];
               use_word = 1'b1;
            end
            // low 12 bits, scaled by access size
            A64_ADD_LO12, A64_LDST8_LO12: begin
               w[21:10] = item.value[11:0];
               use_word = 1'b1;
            end
            A64_LDST16_LO12: begin
               bad      = item.value[0];
               w[21:10] = {1'b0, item.value[11:1]};
               use_word = 1'b1;
            end
            A64_LDST32_LO12: begin
               bad      = |item.value[1:0];
               w[21:10] = {2'b0, item.value[11:2]};
               use_word = 1'b1;
            end
            A64_LDST64_LO12: begin
               bad      = |item.value[2:0];
               w[21:10] = {3'b0, item.value[11:3]};
               use_word = 1'b1;
            end
            A64_LDST128_LO12: begin
               bad      = |item.value[3:0];
               w[21:10] = {4'b0, item.value[11:4]};
               use_word = 1'b1;
            end
            default: unsup = 1'b1;
         endcase
         if (use_word) begin
            d64 = {32'b0, w};
         end
      end
   end

   // final status and data
   always_comb begin
      res_in.valid = item.valid;
      if (unsup) begin
         res_in.status = ST_UNSUP;
         res_in.size   = SZ_NONE;
         res_in.data   = '0;
      end else if (bad) begin
         res_in.status = ST_RANGE;
         res_in.size   = SZ_NONE;
         res_in.data   = '0;
      end else begin
         res_in.status = ST_OK;
         res_in.size   = sz;
         res_in.data   = d64;
      end
   end

   // result register, valid cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
      res_ff.status <= res_in.status;
      res_ff.size   <= res_in.size;
      res_ff.data   <= res_in.data;
   end

   assign result = res_ff;

   // checks
   `ERP_ASSERT_NEXT(a_item_gives_result, item.valid, res_ff.valid)
   `ERP_ASSERT_IMPLY(a_fail_no_write, res_ff.valid && res_ff.status != ST_OK, res_ff.size == SZ_NONE && res_ff.data == '0)
   `ERP_ASSERT_IMPLY(a_word_upper_zero, res_ff.valid && res_ff.size == SZ_W32, res_ff.data[63:32] == '0)
   `ERP_ASSERT_IMPLY(a_no_write_zero, res_ff.valid && res_ff.size == SZ_NONE, res_ff.data == '0)

endmodule

// ===== rtl/elf_relocation_patcher.sv =====
// ----------------------------------------------------------------------------
// elf_relocation_patcher
// ELF64 RELA relocation patcher for x86-64 and AArch64 relocation types.
// ----------------------------------------------------------------------------
// One relocation item is taken in every cycle that start is high; busy is
// always low. Each item gives exactly one result, shown for a single cycle
// with rsp_valid high, in the order the items came in. Each item passes the
// input register, the symbol plus addend adder register and then the result
// register of the stage that forms the pc-relative and page distances,
// decodes the type, checks range and alignment and inserts the immediate.
// There is no backpressure: the receiver must take every result in the cycle
// it is shown. Write csr_write_data (0 x86-64, 1 AArch64) only while no item
// is in flight; it resets to AArch64.
// ----------------------------------------------------------------------------
module elf_relocation_patcher
   import erp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_patch_address,
   input  logic [63:0] req_symbol_value,
   input  logic [63:0] req_addend,
   input  logic [8:0]  req_reloc_type,
   input  logic [31:0] req_old_word,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_write_size,
   output logic [63:0] rsp_write_data,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic           isa_ff;
   logic           isa_in;
   logic           accept;
   erp_item_type   item;
   erp_result_type result;

   // target isa register
   assign isa_in = csr_write_enable ? csr_write_data : isa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         isa_ff <= ISA_RESET;
      end else begin
         isa_ff <= isa_in;
      end
   end

   // fully pipelined, never stalls
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   erp_add_stage u_add (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .isa           (isa_ff),
      .patch_address (req_patch_address),
      .symbol_value  (req_symbol_value),
      .addend        (req_addend),
      .reloc_type    (req_reloc_type),
      .old_word      (req_old_word),
      .item          (item)
   );

   erp_patch_stage u_patch (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .result (result)
   );

   // result ports
   assign rsp_valid      = result.valid;
   assign rsp_status     = result.status;
   assign rsp_write_size = result.size;
   assign rsp_write_data = result.data;

endmodule

// ===== tb/tb_elf_relocation_patcher.sv =====
// ----------------------------------------------------------------------------
// tb_elf_relocation_patcher
// Self-checking bench: relocation items go in through the start/busy port and
// every rsp_valid result is checked field by field against a predictor of
// the x86-64 and AArch64 patch rules. The target isa register is switched
// between phases, and the sender idles at several rates.
// ----------------------------------------------------------------------------
module tb_elf_relocation_patcher
   import erp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RUN_LIMIT  = 200000;
   localparam int          REPORT_CAP = 10;
   localparam int          PHASES     = 8;
   localparam int          PHASE_ITEMS = 240;
   localparam logic [8:0]  R_UNKNOWN  = 9'h1FF;

   // one relocation item as it goes into the block
   typedef struct packed {
      logic [63:0] place;
      logic [63:0] symbol;
      logic [63:0] addend;
      logic [8:0]  rtype;
      logic [31:0] word;
   } reloc_item_type;

   // one patch result as it comes out
   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  size;
      logic [63:0] data;
   } patch_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_patch_address = '0;
   logic [63:0] req_symbol_value = '0;
   logic [63:0] req_addend = '0;
   logic [8:0]  req_reloc_type = '0;
   logic [31:0] req_old_word = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_write_size;
   logic [63:0] rsp_write_data;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   reloc_item_type   pending_relocs[$];
   patch_result_type expected_patches[$];
   logic             isa_model;
   int               sender_idle_pct = 0;
   int               mismatches = 0;
   int               cycles = 0;

   elf_relocation_patcher u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_patch_address (req_patch_address),
      .req_symbol_value  (req_symbol_value),
      .req_addend        (req_addend),
      .req_reloc_type    (req_reloc_type),
      .req_old_word      (req_old_word),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_write_size    (rsp_write_size),
      .rsp_write_data    (rsp_write_data),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("tb_elf_relocation_patcher: FAIL");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // true when v, read as two's complement, fits in n signed bits
   function automatic bit fits_twos(logic [63:0] v, int n);
      logic [63:0] half;
      half = 64'd1 << (n - 1);
      return (v + half) < (half << 1);
   endfunction

   // replace bits pos+len-1..pos of an instruction word with the low bits of v
   function automatic logic [31:0] set_field(logic [31:0] w, int pos, int len,
                                             logic [63:0] v);
      logic [63:0] mask;
      logic [63:0] shifted;
      mask = ((64'd1 << len) - 64'd1) << pos;
      shifted = (v << pos) & mask;
      return (w & ~mask[31:0]) | shifted[31:0];
   endfunction

   // expected store for one relocation under the given isa
   function automatic patch_result_type predict_patch(logic isa, reloc_item_type r);
      logic [63:0]      value;
      logic [63:0]      rel;
      logic [63:0]      page_dist;
      logic [63:0]      off;
      logic [31:0]      w;
      patch_result_type res;
      int               scale;
      int               width;
      int               grp;
      bit               checked;
      value = r.symbol + r.addend;
      rel = value - r.place;
      w = r.word;
      res = '{ST_UNSUP, SZ_NONE, 64'd0};
      scale = -1;
      width = 0;
      if (isa == ISA_X86) begin
         case (r.rtype)
            R_NONE:   res.status = ST_OK;
            X86_64:   res = '{ST_OK, SZ_W64, value};
            X86_PC64: res = '{ST_OK, SZ_W64, rel};
            X86_PC32, X86_PLT32: begin
               if (fits_twos(rel, 32)) res = '{ST_OK, SZ_W32, {32'd0, rel[31:0]}};
               else res.status = ST_RANGE;
            end
            X86_32: begin
               if (value[63:32] == 32'd0) res = '{ST_OK, SZ_W32, value};
               else res.status = ST_RANGE;
            end
            X86_32S: begin
               if (fits_twos(value, 32)) res = '{ST_OK, SZ_W32, {32'd0, value[31:0]}};
               else res.status = ST_RANGE;
            end
            default: ;
         endcase
      end else begin
         case (r.rtype)
            R_NONE:     res.status = ST_OK;
            A64_ABS64:  res = '{ST_OK, SZ_W64, value};
            A64_PREL64: res = '{ST_OK, SZ_W64, rel};
            A64_ABS32: begin
               if (value[63:32] == 32'd0) res = '{ST_OK, SZ_W32, value};
               else res.status = ST_RANGE;
            end
            A64_PREL32: begin
               if (fits_twos(rel, 32)) res = '{ST_OK, SZ_W32, {32'd0, rel[31:0]}};
               else res.status = ST_RANGE;
            end
            // movw groups: 16-bit slice of value into imm16
            A64_MOVW_G0, A64_MOVW_G0_NC, A64_MOVW_G1, A64_MOVW_G1_NC,
            A64_MOVW_G2, A64_MOVW_G2_NC, A64_MOVW_G3: begin
               grp = int'(r.rtype - A64_MOVW_G0) / 2;
               checked = (r.rtype == A64_MOVW_G0) || (r.rtype == A64_MOVW_G1) ||
                         (r.rtype == A64_MOVW_G2);
               if (checked && (value >> (grp * 16 + 16)) != 64'd0) begin
                  res.status = ST_RANGE;
               end else begin
                  w = set_field(w, 5, 16, value >> (grp * 16));
                  res = '{ST_OK, SZ_W32, {32'd0, w}};
               end
            end
            A64_LD_LO19, A64_CONDBR19: width = 21;
            A64_TSTBR14:               width = 16;
            A64_JUMP26, A64_CALL26:    width = 28;
            A64_ADR_LO21: begin
               if (fits_twos(rel, 21)) begin
                  w = set_field(w, 29, 2, rel);
                  w = set_field(w, 5, 19, rel >> 2);
                  res = '{ST_OK, SZ_W32, {32'd0, w}};
               end else begin
                  res.status = ST_RANGE;
               end
            end
            // page distance, checked only for the plain adrp form
            A64_ADRP, A64_ADRP_NC: begin
               page_dist = {value[63:12], 12'd0} - {r.place[63:12], 12'd0};
               if (r.rtype == A64_ADRP && !fits_twos(page_dist, 33)) begin
                  res.status = ST_RANGE;
               end else begin
                  w = set_field(w, 29, 2, page_dist >> 12);
                  w = set_field(w, 5, 19, page_dist >> 14);
                  res = '{ST_OK, SZ_W32, {32'd0, w}};
               end
            end
            A64_ADD_LO12, A64_LDST8_LO12: scale = 0;
            A64_LDST16_LO12:              scale = 1;
            A64_LDST32_LO12:              scale = 2;
            A64_LDST64_LO12:              scale = 3;
            A64_LDST128_LO12:             scale = 4;
            default: ;
         endcase

         // branch and literal forms: signed range plus word alignment
         if (width != 0) begin
            if (!fits_twos(rel, width) || rel[1:0] != 2'd0) begin
               res = '{ST_RANGE, SZ_NONE, 64'd0};
            end else begin
               if (width == 28) w = set_field(w, 0, 26, rel >> 2);
               else if (width == 16) w = set_field(w, 5, 14, rel >> 2);
               else w = set_field(w, 5, 19, rel >> 2);
               res = '{ST_OK, SZ_W32, {32'd0, w}};
            end
         end

         // low 12 bits, scaled by the access size
         if (scale >= 0) begin
            off = value & 64'hFFF;
            if ((off & ((64'd1 << scale) - 64'd1)) != 64'd0) begin
               res = '{ST_RANGE, SZ_NONE, 64'd0};
            end else begin
               w = set_field(w, 10, 12, off >> scale);
               res = '{ST_OK, SZ_W32, {32'd0, w}};
            end
         end
      end
      return res;
   endfunction

   // types whose target is measured from the patch address
   function automatic bit pc_relative(logic isa, logic [8:0] t);
      if (isa == ISA_X86) return t == X86_PC32 || t == X86_PLT32 || t == X86_PC64;
      case (t)
         A64_PREL64, A64_PREL32, A64_LD_LO19, A64_ADR_LO21, A64_ADRP, A64_ADRP_NC,
         A64_TSTBR14, A64_CONDBR19, A64_JUMP26, A64_CALL26: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // magnitudes spread over all bit widths, with values at each power of two
   function automatic logic [63:0] spread64();
      logic [63:0] base;
      logic [63:0] v;
      base = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 3))
         0: v = rand64() & (base - 64'd1);
         1: v = base + $urandom_range(0, 8) - 64'd4;
         2: v = base + 64'd4096 * $urandom_range(0, 2) - 64'd4096 + $urandom_range(0, 4095);
         default: v = rand64();
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   task automatic queue_raw(logic [63:0] place, logic [63:0] symbol, logic [63:0] addend,
                            logic [8:0] t);
      reloc_item_type r;
      r = '{place, symbol, addend, t, $urandom};
      pending_relocs.push_back(r);
   endtask

   // item aimed at a given value; symbol random so the addend wraps freely
   task automatic queue_item(logic [8:0] t, logic [63:0] place, logic [63:0] value);
      logic [63:0] symbol;
      symbol = rand64();
      queue_raw(place, symbol, value - symbol, t);
   endtask

   task automatic queue_random(logic isa);
      logic [63:0] m;
      logic [63:0] bits;
      logic [63:0] place;
      logic [8:0]  t;
      place = rand64();
      bits = rand64();
      if ($urandom_range(0, 9) == 0) begin
         // noise: any type number, unrelated operands
         queue_raw(place, rand64(), rand64(), bits[8:0]);
      end else begin
         if (isa == ISA_X86) begin
            case ($urandom_range(0, 6))
               0: t = R_NONE;
               1: t = X86_64;
               2: t = X86_PC32;
               3: t = X86_PLT32;
               4: t = X86_32;
               5: t = X86_32S;
               default: t = X86_PC64;
            endcase
         end else begin
            case ($urandom_range(0, 19))
               0: t = R_NONE;
               1: t = A64_LDST128_LO12;
               default: t = A64_ABS64 + bits[4:0] % 9'd30;
            endcase
         end
         m = spread64();
         if ($urandom_range(0, 1) == 1) m[3:0] = 4'd0;
         queue_item(t, place, pc_relative(isa, t) ? place + m : m);
      end
   endtask

   // block until every queued item is in and every result is back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_relocs.size() != 0 || start || expected_patches.size() != 0);
   endtask

   task automatic set_isa(logic isa);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= isa;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("mismatch: %s", msg);
   endtask

   // sender: present the next item, hold it until taken
   always @(posedge clock) begin : sender
      reloc_item_type r;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_relocs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            r = pending_relocs.pop_front();
            req_patch_address <= r.place;
            req_symbol_value <= r.symbol;
            req_addend <= r.addend;
            req_reloc_type <= r.rtype;
            req_old_word <= r.word;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: track the isa register, predict taken items, check results
   always @(posedge clock) begin : monitor
      patch_result_type want;
      reloc_item_type   taken;
      if (reset) begin
         isa_model = ISA_RESET;
      end else begin
         if (csr_write_enable) isa_model = csr_write_data;
         if (start && !busy) begin
            taken = '{req_patch_address, req_symbol_value, req_addend, req_reloc_type,
                      req_old_word};
            expected_patches.push_back(predict_patch(isa_model, taken));
         end
         if (rsp_valid) begin
            if (expected_patches.size() == 0) begin
               flag($sformatf("result with nothing expected: status %0d size %0d data %h",
                              rsp_status, rsp_write_size, rsp_write_data));
            end else begin
               want = expected_patches.pop_front();
               if (rsp_status !== want.status)
                  flag($sformatf("status expected %0d got %0d", want.status, rsp_status));
               if (rsp_write_size !== want.size)
                  flag($sformatf("write_size expected %0d got %0d", want.size,
                                 rsp_write_size));
               if (rsp_write_data !== want.data)
                  flag($sformatf("write_data expected %h got %h", want.data,
                                 rsp_write_data));
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [63:0] p;
      logic [8:0]  t;
      p = 64'h0000_7F00_1234_5678;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // aarch64 corners at the reset value of the isa register
      queue_item(R_NONE, p, rand64());
      queue_raw(p, '1, 64'd2, A64_ABS64);
      queue_item(A64_ABS32, p, 64'hFFFF_FFFF);
      queue_item(A64_ABS32, p, 64'h1_0000_0000);
      queue_item(A64_PREL64, p, p - 64'd1);
      queue_item(A64_PREL32, p, p - 64'h8000_0000);
      queue_item(A64_PREL32, p, p + 64'h8000_0000);
      queue_item(A64_MOVW_G0, p, 64'hFFFF);
      queue_item(A64_MOVW_G0, p, 64'h1_0000);
      for (t = A64_MOVW_G0_NC; t <= A64_MOVW_G3; t = t + 9'd1)
         queue_item(t, p, 64'h0000_FFFF_FFFF_FFFF);
      queue_item(A64_LD_LO19, p, p + 64'hF_FFFC);
      queue_item(A64_CONDBR19, p, p + 64'd2);
      queue_item(A64_TSTBR14, p, p - 64'h8000);
      queue_item(A64_JUMP26, p, p + 64'h800_0000);
      queue_item(A64_CALL26, p, p - 64'h800_0000);
      queue_item(A64_ADR_LO21, p, p - 64'h10_0000);
      queue_item(A64_ADRP, p, p + 64'h1_0000_0000);
      queue_item(A64_ADRP_NC, p, p + 64'h1_0000_0000);
      queue_item(A64_ADD_LO12, p, 64'hFFF);
      queue_item(A64_LDST64_LO12, p, 64'hFF8);
      queue_item(A64_LDST128_LO12, p, 64'h8);
      queue_item(R_UNKNOWN, p, 64'd0);
      queue_item(X86_64, p, 64'd0);

      // x86-64 corners
      set_isa(ISA_X86);
      queue_item(R_NONE, p, rand64());
      queue_item(X86_64, p, rand64());
      queue_item(X86_PC64, p, p - 64'd8);
      queue_item(X86_PC32, p, p + 64'h7FFF_FFFF);
      queue_item(X86_PLT32, p, p - 64'h8000_0001);
      queue_item(X86_32, p, 64'hFFFF_FFFF);
      queue_item(X86_32, p, 64'h1_0000_0000);
      queue_item(X86_32S, p, '1);
      queue_item(X86_32S, p, 64'h8000_0000);
      queue_item(A64_ABS64, p, 64'd0);

      // random phases, isa alternating, sender idling at varied rates
      for (int ph = 0; ph < PHASES; ph++) begin
         set_isa(ph % 2 == 0 ? ISA_A64 : ISA_X86);
         case (ph % 4)
            1: sender_idle_pct = 46;
            3: sender_idle_pct = 16;
            default: sender_idle_pct = 0;
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) queue_random(ph % 2 == 0 ? ISA_A64 : ISA_X86);
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0) $display("tb_elf_relocation_patcher: PASS");
      else $display("tb_elf_relocation_patcher: FAIL");
      $finish;
   end

endmodule
